/* rtl/core/ppm_sum_frame_decoder_macros.svh */
// ----------------------------------------------------------------------------
// PPM-sum frame decoder assertion macros
// Shared property wrappers used by the decoder's embedded checks.
// ----------------------------------------------------------------------------
`ifndef PPM_SUM_FRAME_DECODER_MACROS_SVH
`define PPM_SUM_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/psfd_pkg.sv */
// ----------------------------------------------------------------------------
// PPM-sum frame decoder package
// Types, codes and sizing constants shared by the decoder files.
// ----------------------------------------------------------------------------
package psfd_pkg;

  // Number of channel slots in one frame (1 to 255).
  localparam int MAX_CHANNELS = 12;
  // Slot counter width: must hold MAX_CHANNELS itself.
  localparam int SLOT_W = $clog2(MAX_CHANNELS + 1);
  // Channel memory address width.
  localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam int WIDTH_W = 16;
  localparam int CHAN_W = 8;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Reset values of the configuration registers.
  localparam logic [WIDTH_W-1:0] SYNC_MIN_RST = 16'd3000;
  localparam logic [WIDTH_W-1:0] PULSE_MIN_RST = 16'd800;
  localparam logic [WIDTH_W-1:0] PULSE_MAX_RST = 16'd2200;
  localparam logic [WIDTH_W-1:0] TIMEOUT_RST = 16'd100;

  typedef enum logic [1:0] {
    ACT_PULSE      = 2'd0,
    ACT_WINDOW_END = 2'd1,
    ACT_READ       = 2'd2,
    ACT_TICK       = 2'd3
  } psfd_action_t;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_TIMEOUT = 2'd2
  } psfd_status_t;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_SYNC_MIN  = 3'd1,
    REG_PULSE_MIN = 3'd2,
    REG_PULSE_MAX = 3'd3,
    REG_TIMEOUT   = 3'd4
  } psfd_reg_t;

endpackage

/* rtl/core/psfd_if.sv */
// ----------------------------------------------------------------------------
// PPM-sum frame decoder channel interfaces
// Valid/ready channels for input items and read results.
// ----------------------------------------------------------------------------

// Input item channel.
interface psfd_in_if
  import psfd_pkg::*;
  ();
  logic               valid;
  logic               ready;
  psfd_action_t       action;
  logic [WIDTH_W-1:0] period_width;
  logic [CHAN_W-1:0]  read_channel;

  modport source (output valid, output action, output period_width,
                  output read_channel, input ready);
  modport sink (input valid, input action, input period_width,
                input read_channel, output ready);
endinterface

// Read result channel.
interface psfd_out_if
  import psfd_pkg::*;
  ();
  logic               valid;
  logic               ready;
  psfd_status_t       read_status;
  logic [WIDTH_W-1:0] read_value;

  modport source (output valid, output read_status, output read_value, input ready);
  modport sink (input valid, input read_status, input read_value, output ready);
endinterface

/* rtl/core/psfd_chan_mem.sv */
// ----------------------------------------------------------------------------
// PPM-sum channel store
// Single-write, single-read channel width memory with registered read data.
// ----------------------------------------------------------------------------
module psfd_chan_mem
  import psfd_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [CH_AW-1:0]   wr_addr,
  input  logic [WIDTH_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [CH_AW-1:0]   rd_addr,
  output logic [WIDTH_W-1:0] rd_data
);

  logic [WIDTH_W-1:0] mem_r [MAX_CHANNELS];
  logic [WIDTH_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port: data held until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/ppm_sum_frame_decoder.sv */
// ----------------------------------------------------------------------------
// PPM-sum frame decoder
// Captures channel widths from pulse periods and serves channel reads.
// ----------------------------------------------------------------------------
//  Channel    Direction  Contents
//  in_chan    in         action, period_width, read_channel
//  out_chan   out        read_status, read_value (read actions only)
//  psel/...   in/out     APB register port, five 32-bit registers at 4*i
//
//  One item is accepted per cycle unless the input is stalled; pulse,
//  window-end and tick items finish in the cycle they are accepted.
//  A read result passes through the synchronous read of the channel memory
//  and then the output register.
//  rst_n is synchronous and active low; the channel memory is not cleared.
//  A stalled result holds the output register; input stalls only once the
//  read stage behind it is also full.
// ----------------------------------------------------------------------------
`include "ppm_sum_frame_decoder_macros.svh"

module ppm_sum_frame_decoder
  import psfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  psfd_in_if.sink           in_chan,
  psfd_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers.
  logic               enable_r;
  logic [WIDTH_W-1:0] sync_min_r;
  logic [WIDTH_W-1:0] pulse_min_r;
  logic [WIDTH_W-1:0] pulse_max_r;
  logic [WIDTH_W-1:0] timeout_r;

  // Frame state.
  logic [SLOT_W-1:0]  slot_index_r, slot_index_nxt;
  logic               frame_ended_r, frame_ended_nxt;
  logic [SLOT_W-1:0]  committed_r, committed_nxt;
  logic [WIDTH_W-1:0] frame_age_r, frame_age_nxt;

  // Read stage and output register.
  logic               s1_valid_r, s1_valid_nxt;
  psfd_status_t       s1_status_r, s1_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  psfd_status_t       out_status_r, out_status_nxt;
  logic [WIDTH_W-1:0] out_value_r, out_value_nxt;

  logic               accept;
  logic               s1_adv;
  logic               cfg_wr;
  psfd_reg_t          cfg_idx;
  logic               pulse_open;
  logic               is_sync;
  logic               in_band;
  logic               mem_wr;
  logic               mem_rd;
  psfd_status_t       rd_status;
  logic [WIDTH_W-1:0] mem_rdata;

  // APB register port.
  assign pready = 1'b1;
  assign cfg_idx = psfd_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      sync_min_r  <= SYNC_MIN_RST;
      pulse_min_r <= PULSE_MIN_RST;
      pulse_max_r <= PULSE_MAX_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:    enable_r    <= pwdata[0];
        REG_SYNC_MIN:  sync_min_r  <= pwdata[WIDTH_W-1:0];
        REG_PULSE_MIN: pulse_min_r <= pwdata[WIDTH_W-1:0];
        REG_PULSE_MAX: pulse_max_r <= pwdata[WIDTH_W-1:0];
        REG_TIMEOUT:   timeout_r   <= pwdata[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_ENABLE:    prdata = CFG_DW'(enable_r);
      REG_SYNC_MIN:  prdata = CFG_DW'(sync_min_r);
      REG_PULSE_MIN: prdata = CFG_DW'(pulse_min_r);
      REG_PULSE_MAX: prdata = CFG_DW'(pulse_max_r);
      REG_TIMEOUT:   prdata = CFG_DW'(timeout_r);
      default:       prdata = '0;
    endcase
  end

  // Handshake: the read stage moves on when the output register is free.
  assign s1_adv = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign accept = in_chan.valid && in_chan.ready;

  // Pulse classification against the sync threshold and the valid band.
  assign pulse_open = !frame_ended_r && (slot_index_r < SLOT_W'(MAX_CHANNELS));
  assign is_sync = in_chan.period_width >= sync_min_r;
  assign in_band = !is_sync && (in_chan.period_width >= pulse_min_r)
                   && (in_chan.period_width <= pulse_max_r);
  assign mem_wr = accept && (in_chan.action == ACT_PULSE) && pulse_open && in_band;

  // Read status from the committed frame; the width comes from memory.
  always_comb begin
    if (!enable_r || (in_chan.read_channel >= CHAN_W'(committed_r))
        || (in_chan.read_channel >= CHAN_W'(MAX_CHANNELS))) begin
      rd_status = ST_INVALID;
    end else if (frame_age_r > timeout_r) begin
      rd_status = ST_TIMEOUT;
    end else begin
      rd_status = ST_VALID;
    end
  end

  assign mem_rd = accept && (in_chan.action == ACT_READ) && (rd_status == ST_VALID);

  psfd_chan_mem u_chan_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (slot_index_r[CH_AW-1:0]),
    .wr_data (in_chan.period_width),
    .rd_en   (mem_rd),
    .rd_addr (in_chan.read_channel[CH_AW-1:0]),
    .rd_data (mem_rdata)
  );

  // Frame state update per accepted item.
  always_comb begin
    slot_index_nxt  = slot_index_r;
    frame_ended_nxt = frame_ended_r;
    committed_nxt   = committed_r;
    frame_age_nxt   = frame_age_r;
    if (accept) begin
      case (in_chan.action)
        ACT_PULSE: begin
          if (pulse_open) begin
            if (is_sync) begin
              if (slot_index_r != '0) begin
                frame_ended_nxt = 1'b1;
              end
            end else if (in_band) begin
              slot_index_nxt = slot_index_r + SLOT_W'(1);
            end
          end
        end
        ACT_WINDOW_END: begin
          if (slot_index_r != '0) begin
            committed_nxt = slot_index_r;
            frame_age_nxt = '0;
          end
          slot_index_nxt  = '0;
          frame_ended_nxt = 1'b0;
        end
        ACT_TICK: begin
          if (frame_age_r != '1) begin
            frame_age_nxt = frame_age_r + WIDTH_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Read stage and output register next values.
  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    s1_status_nxt  = s1_status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (s1_adv) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = s1_status_r;
      out_value_nxt  = (s1_status_r == ST_VALID) ? mem_rdata : '0;
      s1_valid_nxt   = 1'b0;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && (in_chan.action == ACT_READ)) begin
      s1_valid_nxt  = 1'b1;
      s1_status_nxt = rd_status;
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_index_r  <= '0;
      frame_ended_r <= 1'b0;
      committed_r   <= '0;
      frame_age_r   <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      slot_index_r  <= slot_index_nxt;
      frame_ended_r <= frame_ended_nxt;
      committed_r   <= committed_nxt;
      frame_age_r   <= frame_age_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_status_r  <= s1_status_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_status = out_status_r;
  assign out_chan.read_value  = out_value_r;

  // Embedded checks.
  `PSFD_ASSERT_IMPL(a_slot_bound, clk, rst_n, 1'b1,
                    slot_index_r <= SLOT_W'(MAX_CHANNELS), "slot index past the last slot")
  `PSFD_ASSERT_IMPL(a_commit_bound, clk, rst_n, 1'b1,
                    committed_r <= SLOT_W'(MAX_CHANNELS), "committed count past the last slot")
  `PSFD_ASSERT_IMPL(a_end_needs_chan, clk, rst_n, frame_ended_r,
                    slot_index_r != '0, "frame ended with no channel captured")
  `PSFD_ASSERT_IMPL(a_full_stall, clk, rst_n, s1_valid_r && out_valid_r && !out_chan.ready,
                    !in_chan.ready, "input taken while both result stages are blocked")
  `PSFD_ASSERT_NEXT(a_read_lands, clk, rst_n, accept && (in_chan.action == ACT_READ),
                    s1_valid_r, "accepted read did not reach the read stage")

endmodule
